>>> hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define AST_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication in the next cycle
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/wfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wfsc_pkg;
	localparam int CLASS_ENTRIES = 64;
	localparam int CLASS_IDX_W = 6;
	localparam int ADDR_W = 48;
	localparam int FCNT_W = 32;
	localparam int BCNT_W = 48;
	localparam int LEN_W = 16;

	typedef enum logic [1:0] {
		ACT_COUNT = 2'd0,
		ACT_READ_CLASS = 2'd1,
		ACT_READ_PAIR = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_READ = 2'd1,
		OP_IDLE = 2'd2
	} op_t;

	// token that walks the pair chain
	typedef struct packed {
		logic active;
		op_t op;
		logic hit;
		logic [CLASS_IDX_W-1:0] idx;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [FCNT_W-1:0] cnt;
	} token_t;
endpackage
`default_nettype wire

>>> hdl/wfsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module wfsc_cell #(
	parameter int IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wfsc_pkg::token_t tok_in,
	output wfsc_pkg::token_t tok_out
);
	logic used_q;
	logic [wfsc_pkg::ADDR_W-1:0] src_q;
	logic [wfsc_pkg::ADDR_W-1:0] dst_q;
	logic [wfsc_pkg::FCNT_W-1:0] cnt_q;
	wfsc_pkg::token_t tok_q;
	wfsc_pkg::token_t nxt;
	logic claim;
	logic bump;
	logic [wfsc_pkg::FCNT_W-1:0] cnt_inc;

	assign cnt_inc = cnt_q + 1'b1;

	// match, claim or read as the token passes
	always_comb begin
		nxt = tok_in;
		claim = 1'b0;
		bump = 1'b0;
		if (tok_in.active) begin
			unique case (tok_in.op)
				wfsc_pkg::OP_COUNT: begin
					if (!tok_in.hit) begin
						if (used_q && src_q == tok_in.src && dst_q == tok_in.dst) begin
							bump = 1'b1;
							nxt.hit = 1'b1;
							nxt.cnt = cnt_inc;
						end else if (!used_q) begin
							claim = 1'b1;
							nxt.hit = 1'b1;
							nxt.cnt = {{(wfsc_pkg::FCNT_W-1){1'b0}}, 1'b1};
						end
					end
				end
				wfsc_pkg::OP_READ: begin
					if (32'(tok_in.idx) == 32'(IDX) && used_q) begin
						nxt.hit = 1'b1;
						nxt.cnt = cnt_q;
						nxt.src = src_q;
						nxt.dst = dst_q;
					end
				end
				default: ;
			endcase
		end
	end

	// entry state and token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			cnt_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
			if (claim) begin
				used_q <= 1'b1;
				cnt_q <= {{(wfsc_pkg::FCNT_W-1){1'b0}}, 1'b1};
			end else if (bump) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	// addresses only read while used
	always_ff @(posedge clk) begin
		if (claim) begin
			src_q <= tok_in.src;
			dst_q <= tok_in.dst;
		end
	end

	assign tok_out = tok_q;
endmodule
`default_nettype wire

>>> hdl/wfsc_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module wfsc_chain #(
	parameter int ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wfsc_pkg::token_t tok_in,
	output wfsc_pkg::token_t tok_out
);
	wfsc_pkg::token_t link [ENTRIES+1];

	assign link[0] = tok_in;

	// one cell per pair entry
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		wfsc_cell #(.IDX(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(link[g]),
			.tok_out(link[g+1])
		);
	end

	assign tok_out = link[ENTRIES];
endmodule
`default_nettype wire

>>> hdl/wifi_frame_statistics_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// 802.11 frame statistics counter.
// Request channel: an item transfers on a rising edge with start high and
// busy low. action selects count frame, read class/subtype counter or read
// pair entry. Result channel: done is high for exactly one cycle with all
// result ports valid; the receiver takes it then and cannot stall.
// done rises for every action once the token has left the pair table. busy
// stays high until done, so one item is in flight at a time. The pair
// table is a row of PAIR_ENTRIES cells that a token walks one cell per
// cycle, matching, claiming the first free entry or returning the addressed
// entry. Class/subtype counters live in a 64-entry memory updated by
// read-modify-write while the token walks.
// Reset clears totals and pair entries at once and marks every class counter
// invalid so it reads as zero; the block is ready in the first cycle after reset.
module wifi_frame_statistics_counter #(
	parameter int PAIR_ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] action,
	input wire logic [7:0] frame_control,
	input wire logic [47:0] receiver_addr,
	input wire logic [47:0] transmitter_addr,
	input wire logic [15:0] frame_length,
	input wire logic [5:0] read_index,
	output logic done,
	output logic [31:0] class_frame_count,
	output logic [47:0] class_byte_count,
	output logic [31:0] pair_frame_count,
	output logic [47:0] pair_source,
	output logic [47:0] pair_dest,
	output logic entry_valid,
	output logic [31:0] total_frames,
	output logic [47:0] total_bytes,
	output logic [1:0] status
);
	logic busy_q;
	logic done_q;
	logic upd_q;
	wfsc_pkg::action_t act_q;
	logic [wfsc_pkg::LEN_W-1:0] len_q;
	logic [5:0] ridx_q;
	logic [wfsc_pkg::CLASS_IDX_W-1:0] caddr_q;
	wfsc_pkg::token_t tok_in_q;
	wfsc_pkg::token_t tok_end;
	logic [wfsc_pkg::FCNT_W-1:0] cf_mem [wfsc_pkg::CLASS_ENTRIES];
	logic [wfsc_pkg::BCNT_W-1:0] cb_mem [wfsc_pkg::CLASS_ENTRIES];
	logic [wfsc_pkg::CLASS_ENTRIES-1:0] cvalid_q;
	logic [wfsc_pkg::FCNT_W-1:0] crd_f_q;
	logic [wfsc_pkg::BCNT_W-1:0] crd_b_q;
	logic crd_v_q;
	logic [wfsc_pkg::FCNT_W-1:0] cf_cur;
	logic [wfsc_pkg::BCNT_W-1:0] cb_cur;
	logic [wfsc_pkg::FCNT_W-1:0] cf_new;
	logic [wfsc_pkg::BCNT_W-1:0] cb_new;
	logic [wfsc_pkg::FCNT_W-1:0] res_cf_q;
	logic [wfsc_pkg::BCNT_W-1:0] res_cb_q;
	logic [wfsc_pkg::FCNT_W-1:0] tot_f_q;
	logic [wfsc_pkg::BCNT_W-1:0] tot_b_q;
	logic [wfsc_pkg::CLASS_IDX_W-1:0] addr;
	logic accept;
	logic cwrite;
	wfsc_pkg::status_t st;

	assign accept = start && !busy_q;
	assign addr = (wfsc_pkg::action_t'(action) == wfsc_pkg::ACT_COUNT) ?
		{frame_control[3:2], frame_control[7:4]} : read_index;
	assign cf_cur = crd_v_q ? crd_f_q : '0;
	assign cb_cur = crd_v_q ? crd_b_q : '0;
	assign cf_new = cf_cur + 1'b1;
	assign cb_new = cb_cur + wfsc_pkg::BCNT_W'(len_q);
	assign cwrite = upd_q && act_q == wfsc_pkg::ACT_COUNT;

	// class counter memory, registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			crd_f_q <= cf_mem[addr];
			crd_b_q <= cb_mem[addr];
		end
		if (cwrite) begin
			cf_mem[caddr_q] <= cf_new;
			cb_mem[caddr_q] <= cb_new;
		end
	end

	wfsc_chain #(.ENTRIES(PAIR_ENTRIES)) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.tok_in(tok_in_q),
		.tok_out(tok_end)
	);

	// result status
	always_comb begin
		unique case (act_q)
			wfsc_pkg::ACT_COUNT: st = tok_end.hit ? wfsc_pkg::ST_OK : wfsc_pkg::ST_FULL;
			wfsc_pkg::ACT_READ_CLASS: st = wfsc_pkg::ST_OK;
			wfsc_pkg::ACT_READ_PAIR:
				st = (32'(ridx_q) < 32'(PAIR_ENTRIES)) ? wfsc_pkg::ST_OK : wfsc_pkg::ST_RANGE;
			default: st = wfsc_pkg::ST_RANGE;
		endcase
	end

	// control, totals and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			upd_q <= 1'b0;
			act_q <= wfsc_pkg::ACT_NONE;
			tok_in_q <= '0;
			cvalid_q <= '0;
			crd_v_q <= 1'b0;
			tot_f_q <= '0;
			tot_b_q <= '0;
			res_cf_q <= '0;
			res_cb_q <= '0;
			len_q <= '0;
			ridx_q <= '0;
			caddr_q <= '0;
			class_frame_count <= '0;
			class_byte_count <= '0;
			pair_frame_count <= '0;
			pair_source <= '0;
			pair_dest <= '0;
			entry_valid <= 1'b0;
			total_frames <= '0;
			total_bytes <= '0;
			status <= wfsc_pkg::ST_OK;
		end else begin
			done_q <= tok_end.active;
			upd_q <= accept;
			tok_in_q.active <= accept;
			if (accept) begin
				busy_q <= 1'b1;
				act_q <= wfsc_pkg::action_t'(action);
				len_q <= frame_length;
				ridx_q <= read_index;
				caddr_q <= addr;
				crd_v_q <= cvalid_q[addr];
				tok_in_q.hit <= 1'b0;
				tok_in_q.idx <= read_index;
				tok_in_q.cnt <= '0;
				unique case (wfsc_pkg::action_t'(action))
					wfsc_pkg::ACT_COUNT: begin
						tok_in_q.op <= wfsc_pkg::OP_COUNT;
						tok_in_q.src <= transmitter_addr;
						tok_in_q.dst <= receiver_addr;
					end
					wfsc_pkg::ACT_READ_PAIR: begin
						tok_in_q.op <= wfsc_pkg::OP_READ;
						tok_in_q.src <= '0;
						tok_in_q.dst <= '0;
					end
					default: begin
						tok_in_q.op <= wfsc_pkg::OP_IDLE;
						tok_in_q.src <= '0;
						tok_in_q.dst <= '0;
					end
				endcase
			end
			// class counter update in the cycle after the transfer
			if (upd_q) begin
				unique case (act_q)
					wfsc_pkg::ACT_COUNT: begin
						cvalid_q[caddr_q] <= 1'b1;
						res_cf_q <= cf_new;
						res_cb_q <= cb_new;
						tot_f_q <= tot_f_q + 1'b1;
						tot_b_q <= tot_b_q + wfsc_pkg::BCNT_W'(len_q);
					end
					wfsc_pkg::ACT_READ_CLASS: begin
						res_cf_q <= cf_cur;
						res_cb_q <= cb_cur;
					end
					default: begin
						res_cf_q <= '0;
						res_cb_q <= '0;
					end
				endcase
			end
			// token leaves the chain
			if (tok_end.active) begin
				busy_q <= 1'b0;
				class_frame_count <= res_cf_q;
				class_byte_count <= res_cb_q;
				pair_frame_count <= tok_end.cnt;
				pair_source <= tok_end.src;
				pair_dest <= tok_end.dst;
				entry_valid <= tok_end.hit;
				total_frames <= tot_f_q;
				total_bytes <= tot_b_q;
				status <= st;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> hdl/wfsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wfsc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [31:0] pair_frame_count,
	input wire logic entry_valid,
	input wire logic [1:0] status
);
	// a transfer makes the block busy
	`AST_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	// results are single-cycle strobes
	`AST_NEXT(a_done_single, clk, arst_n, done, !done)
	// a full table gives no pair count
	`AST_SAME(a_full_no_pair, clk, arst_n, done && status == wfsc_pkg::ST_FULL,
		!entry_valid && pair_frame_count == 32'd0)
	// no result status beyond range code
	`AST_SAME(a_status_code, clk, arst_n, done, status <= wfsc_pkg::ST_RANGE)
endmodule

bind wifi_frame_statistics_counter wfsc_checker u_wfsc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.pair_frame_count(pair_frame_count),
	.entry_valid(entry_valid),
	.status(status)
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	localparam int N_PAIRS = 64;
	localparam int MAX_CYCLES = 400000;

	typedef struct {
		wfsc_pkg::action_t act;
		logic [7:0] fc;
		logic [47:0] dst;
		logic [47:0] src;
		logic [15:0] len;
		logic [5:0] idx;
	} frame_req_t;

	typedef struct {
		logic [31:0] cf;
		logic [47:0] cb;
		logic [31:0] pf;
		logic [47:0] ps;
		logic [47:0] pd;
		logic ev;
		logic [31:0] tf;
		logic [47:0] tb;
		logic [1:0] st;
	} stats_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic [7:0] frame_control = '0;
	logic [47:0] receiver_addr = '0;
	logic [47:0] transmitter_addr = '0;
	logic [15:0] frame_length = '0;
	logic [5:0] read_index = '0;
	logic done;
	logic [31:0] class_frame_count;
	logic [47:0] class_byte_count;
	logic [31:0] pair_frame_count;
	logic [47:0] pair_source;
	logic [47:0] pair_dest;
	logic entry_valid;
	logic [31:0] total_frames;
	logic [47:0] total_bytes;
	logic [1:0] status;

	wifi_frame_statistics_counter #(.PAIR_ENTRIES(N_PAIRS)) dut (.*);

	always #5 clk = ~clk;

	// shadow copy of the counters
	logic [31:0] m_cls_frames [64];
	logic [47:0] m_cls_bytes [64];
	logic [31:0] m_tot_frames;
	logic [47:0] m_tot_bytes;
	logic [47:0] m_src [N_PAIRS];
	logic [47:0] m_dst [N_PAIRS];
	logic [31:0] m_pcnt [N_PAIRS];
	logic m_used [N_PAIRS];

	frame_req_t pending_reqs[$];
	stats_rsp_t expected_stats[$];
	int mismatches = 0;
	int cycles = 0;
	bit stim_done = 0;
	int calm = 0;

	function automatic stats_rsp_t predict_stats(frame_req_t r);
		stats_rsp_t o;
		int ci, hit, free_e;
		o = '{default: '0};
		if (r.act == wfsc_pkg::ACT_COUNT) begin
			ci = {r.fc[3:2], r.fc[7:4]};
			hit = -1;
			free_e = -1;
			m_cls_frames[ci] += 1;
			m_cls_bytes[ci] += r.len;
			m_tot_frames += 1;
			m_tot_bytes += r.len;
			for (int k = 0; k < N_PAIRS; k++) begin
				if (m_used[k]) begin
					if (hit < 0 && m_src[k] == r.src && m_dst[k] == r.dst) hit = k;
				end else if (free_e < 0) begin
					free_e = k;
				end
			end
			if (hit < 0 && free_e >= 0) begin
				hit = free_e;
				m_used[hit] = 1'b1;
				m_src[hit] = r.src;
				m_dst[hit] = r.dst;
				m_pcnt[hit] = '0;
			end
			o.cf = m_cls_frames[ci];
			o.cb = m_cls_bytes[ci];
			o.ps = r.src;
			o.pd = r.dst;
			if (hit >= 0) begin
				m_pcnt[hit] += 1;
				o.pf = m_pcnt[hit];
				o.ev = 1'b1;
				o.st = wfsc_pkg::ST_OK;
			end else begin
				o.st = wfsc_pkg::ST_FULL;
			end
		end else if (r.act == wfsc_pkg::ACT_READ_CLASS) begin
			o.cf = m_cls_frames[r.idx];
			o.cb = m_cls_bytes[r.idx];
		end else if (r.act == wfsc_pkg::ACT_READ_PAIR) begin
			if (r.idx < N_PAIRS) begin
				if (m_used[r.idx]) begin
					o.pf = m_pcnt[r.idx];
					o.ps = m_src[r.idx];
					o.pd = m_dst[r.idx];
					o.ev = 1'b1;
				end
			end else begin
				o.st = wfsc_pkg::ST_RANGE;
			end
		end else begin
			o.st = wfsc_pkg::ST_RANGE;
		end
		o.tf = m_tot_frames;
		o.tb = m_tot_bytes;
		return o;
	endfunction

	// driver: one transfer at a time, random gaps outside calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_reqs.size() > 0 && (calm > 0 || $urandom_range(99) >= 20)) begin
				start <= 1'b1;
				action <= pending_reqs[0].act;
				frame_control <= pending_reqs[0].fc;
				receiver_addr <= pending_reqs[0].dst;
				transmitter_addr <= pending_reqs[0].src;
				frame_length <= pending_reqs[0].len;
				read_index <= pending_reqs[0].idx;
			end else begin
				start <= 1'b0;
			end
			if (calm > 0) calm <= calm - 1;
			else if ($urandom_range(999) == 0) calm <= 300;
		end
	end

	// monitor: predict on each transfer, check on each done
	always @(posedge clk) begin
		stats_rsp_t e;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy) expected_stats.push_back(predict_stats(pending_reqs.pop_front()));
			if (done) begin
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
				end else begin
					e = expected_stats.pop_front();
					if (e.cf !== class_frame_count || e.cb !== class_byte_count ||
						e.pf !== pair_frame_count || e.ps !== pair_source ||
						e.pd !== pair_dest || e.ev !== entry_valid ||
						e.tf !== total_frames || e.tb !== total_bytes ||
						e.st !== status) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp cf %0d cb %0d pf %0d ps %h pd %h ev %0d",
								e.cf, e.cb, e.pf, e.ps, e.pd, e.ev);
							$display("  exp tf %0d tb %0d st %0d", e.tf, e.tb, e.st);
							$display("  got cf %0d cb %0d pf %0d ps %h pd %h ev %0d",
								class_frame_count, class_byte_count, pair_frame_count,
								pair_source, pair_dest, entry_valid);
							$display("  got tf %0d tb %0d st %0d",
								total_frames, total_bytes, status);
						end
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic frame_req_t mk(wfsc_pkg::action_t a, logic [7:0] fc,
		logic [47:0] dst, logic [47:0] src, logic [15:0] len, logic [5:0] idx);
		frame_req_t r;
		r.act = a;
		r.fc = fc;
		r.dst = dst;
		r.src = src;
		r.len = len;
		r.idx = idx;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom_range(65535)), $urandom()};
	endfunction

	initial begin
		logic [47:0] stations [8];
		frame_req_t r;
		int k;
		for (int i = 0; i < 64; i++) begin
			m_cls_frames[i] = '0;
			m_cls_bytes[i] = '0;
		end
		for (int i = 0; i < N_PAIRS; i++) begin
			m_used[i] = 1'b0;
			m_pcnt[i] = '0;
			m_src[i] = '0;
			m_dst[i] = '0;
		end
		m_tot_frames = '0;
		m_tot_bytes = '0;
		for (int i = 0; i < 8; i++) stations[i] = rand48();
		stations[0] = '0;
		stations[1] = '1;

		// directed: extremes, reads of empty stores, repeat pair, bad action
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_PAIR, 8'h00, '0, '0, '0, 6'd0));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_CLASS, 8'h00, '0, '0, '0, 6'd63));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'h00, '0, '0, 16'h0000, 6'd0));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'hFF, '1, '1, 16'hFFFF, 6'h3F));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'hFF, '1, '1, 16'hFFFF, 6'h15));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'h84, '1, '0, 16'h1234, 6'h2A));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'h08, '0, '1, 16'h0040, 6'd0));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_CLASS, 8'hFF, '1, '1, '1, 6'd0));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_CLASS, 8'h00, '0, '0, '0, 6'h3F));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_CLASS, 8'h00, '0, '0, '0, 6'h18));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_PAIR, 8'hFF, '1, '1, '1, 6'd1));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_PAIR, 8'h00, '0, '0, '0, 6'd3));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_PAIR, 8'h00, '0, '0, '0, 6'd63));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_NONE, 8'hFF, '1, '1, '1, 6'h3F));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_NONE, 8'h00, '0, '0, '0, 6'd0));

		// fill the table to overflow, count a known pair, then read every entry
		for (int i = 0; i < 70; i++)
			pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'($urandom_range(255)),
				rand48(), rand48(), 16'($urandom_range(65535)), 6'($urandom_range(63))));
		pending_reqs.push_back(mk(wfsc_pkg::ACT_COUNT, 8'h00, '0, '0, 16'd5, 6'd0));
		for (int i = 0; i < 64; i++)
			pending_reqs.push_back(mk(wfsc_pkg::ACT_READ_PAIR, 8'h00, '0, '0, '0, 6'(i)));

		// random: mostly reads plus repeats of known pairs in a full table
		for (int i = 0; i < 1550; i++) begin
			k = $urandom_range(99);
			r = mk(wfsc_pkg::action_t'($urandom_range(3)), 8'($urandom_range(255)),
				rand48(), rand48(), 16'($urandom_range(65535)), 6'($urandom_range(63)));
			if (k < 45) r.act = wfsc_pkg::ACT_COUNT;
			else if (k < 70) r.act = wfsc_pkg::ACT_READ_CLASS;
			else if (k < 95) r.act = wfsc_pkg::ACT_READ_PAIR;
			if (r.act == wfsc_pkg::ACT_COUNT && $urandom_range(3) != 0) begin
				r.src = stations[$urandom_range(7)];
				r.dst = stations[$urandom_range(7)];
			end
			pending_reqs.push_back(r);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0);
		wait (expected_stats.size() == 0);
		repeat (N_PAIRS + 20) @(posedge clk);
		if (mismatches == 0 && expected_stats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
